// ===== hdl/cqs_pkg.sv =====
`timescale 1ns / 1ps
// shared types, widths and codes for the circular queue with search
// no dependencies; imported by every module of the block
package cqs_pkg;

	// fixed field widths
	localparam int KIND_W = 2;
	localparam int DATA_W = 64;
	localparam int POS_W = 4;
	localparam int STATUS_W = 2;
	localparam int CNT_W = 5;

	// parameter defaults
	localparam int DEPTH_DEF = 16;
	localparam int WORD_BITS_DEF = 64;

	// capacity register value after reset
	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

	typedef enum logic [KIND_W-1:0] {
		KIND_ADD    = 2'd0,
		KIND_POP    = 2'd1,
		KIND_SEARCH = 2'd2,
		KIND_GET    = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_REJECT    = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_RANGE     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_GET_WAIT,
		S_SEARCH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic    latch;
		logic    add_wr;
		logic    pop_adv;
		logic    rd_get;
		logic    rd_head;
		logic    rd_next;
		logic    res_en;
		status_t res_status;
		logic    res_data;
		logic    res_found;
	} cqs_cmd_t;

	// datapath to controller
	typedef struct packed {
		kind_t kind;
		logic  full;
		logic  empty;
		logic  pos_ok;
		logic  match;
		logic  last;
	} cqs_stat_t;

endpackage

// ===== hdl/cqs_ctrl.sv =====
`timescale 1ns / 1ps
// controller state machine of the circular queue with search
// depends on cqs_pkg for state, command and status types
module cqs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  cqs_pkg::cqs_stat_t  stat,
	output cqs_pkg::cqs_cmd_t   cmd,
	output logic                busy
);
	import cqs_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.res_status = ST_OK;
		busy = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.latch = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
				unique case (stat.kind)
					KIND_ADD: begin
						cmd.res_en = 1'b1;
						if (stat.full) begin
							cmd.res_status = ST_REJECT;
						end else begin
							cmd.add_wr = 1'b1;
						end
					end
					KIND_POP: begin
						cmd.res_en = 1'b1;
						if (stat.empty) begin
							cmd.res_status = ST_REJECT;
						end else begin
							cmd.pop_adv = 1'b1;
						end
					end
					KIND_GET: begin
						if (stat.pos_ok) begin
							cmd.rd_get = 1'b1;
							state_d = S_GET_WAIT;
						end else begin
							cmd.res_en = 1'b1;
							cmd.res_status = ST_RANGE;
						end
					end
					KIND_SEARCH: begin
						if (stat.empty) begin
							cmd.res_en = 1'b1;
							cmd.res_status = ST_NOT_FOUND;
						end else begin
							cmd.rd_head = 1'b1;
							state_d = S_SEARCH;
						end
					end
					default: begin
						cmd.res_en = 1'b1;
					end
				endcase
			end
			S_GET_WAIT: begin
				cmd.res_en = 1'b1;
				cmd.res_data = 1'b1;
				state_d = S_IDLE;
			end
			S_SEARCH: begin
				priority if (stat.match) begin
					cmd.res_en = 1'b1;
					cmd.res_found = 1'b1;
					state_d = S_IDLE;
				end else if (stat.last) begin
					cmd.res_en = 1'b1;
					cmd.res_status = ST_NOT_FOUND;
					state_d = S_IDLE;
				end else begin
					cmd.rd_next = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/cqs_dp.sv =====
`timescale 1ns / 1ps
// datapath of the circular queue with search: ring memory, pointers, result registers
// depends on cqs_pkg for widths, codes and the command and status structs
module cqs_dp #(
	parameter int DEPTH = cqs_pkg::DEPTH_DEF,
	parameter int WORD_BITS = cqs_pkg::WORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cqs_pkg::cqs_cmd_t             cmd,
	output cqs_pkg::cqs_stat_t            stat,
	input  logic [cqs_pkg::KIND_W-1:0]    kind,
	input  logic [cqs_pkg::DATA_W-1:0]    value,
	input  logic [cqs_pkg::POS_W-1:0]     position,
	input  logic                          capacity_we,
	input  logic [cqs_pkg::CNT_W-1:0]     capacity,
	output logic                          done,
	output logic [cqs_pkg::STATUS_W-1:0]  status,
	output logic [cqs_pkg::DATA_W-1:0]    data_out,
	output logic [cqs_pkg::POS_W-1:0]     found_position,
	output logic [cqs_pkg::CNT_W-1:0]     occupancy
);
	import cqs_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	// largest usable capacity: the register is CNT_W bits
	localparam int CAP_LIM = (DEPTH < (2 ** CNT_W - 1)) ? DEPTH : (2 ** CNT_W - 1);
	localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(CAP_LIM);

	// (a + b) mod cap where both operands stay below cap
	function automatic logic [CNT_W-1:0] ring_add(
		input logic [CNT_W-1:0] a,
		input logic [CNT_W-1:0] b,
		input logic [CNT_W-1:0] cap
	);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, cap}) begin
			s = s - {1'b0, cap};
		end
		return s[CNT_W-1:0];
	endfunction

	// zero reads as one, above the ring size reads as the ring size
	function automatic logic [CNT_W-1:0] clamp_cap(input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] r;
		r = c;
		if (c == '0) begin
			r = CNT_W'(1);
		end else if (c > CAP_MAX) begin
			r = CAP_MAX;
		end
		return r;
	endfunction

	logic [WORD_BITS-1:0] mem [DEPTH];

	kind_t                kind_q;
	logic [WORD_BITS-1:0] value_q;
	logic [POS_W-1:0]     pos_q;
	logic [CNT_W-1:0]     cap_q;
	logic [CNT_W-1:0]     head_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     ptr_q;
	logic [CNT_W-1:0]     k_q;
	logic [WORD_BITS-1:0] rd_data_q;

	logic                 done_q;
	status_t              status_q;
	logic [DATA_W-1:0]    data_q;
	logic [POS_W-1:0]     found_q;
	logic [CNT_W-1:0]     occ_q;

	logic [CNT_W-1:0] tail;
	logic [CNT_W-1:0] get_idx;
	logic [CNT_W-1:0] rd_addr;
	logic [CNT_W-1:0] rd_addr_inc;
	logic [CNT_W-1:0] head_inc;
	logic [CNT_W-1:0] count_d;
	logic             rd_en;

	assign tail     = ring_add(head_q, count_q, cap_q);
	assign get_idx  = ring_add(head_q, CNT_W'(pos_q), cap_q);
	assign head_inc = ring_add(head_q, CNT_W'(1), cap_q);
	assign rd_en    = cmd.rd_get | cmd.rd_head | cmd.rd_next;

	always_comb begin
		priority if (cmd.rd_get) begin
			rd_addr = get_idx;
		end else if (cmd.rd_head) begin
			rd_addr = head_q;
		end else begin
			rd_addr = ptr_q;
		end
	end

	assign rd_addr_inc = ring_add(rd_addr, CNT_W'(1), cap_q);

	always_comb begin
		count_d = count_q;
		if (cmd.add_wr) begin
			count_d = count_q + CNT_W'(1);
		end else if (cmd.pop_adv) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	assign stat.kind   = kind_q;
	assign stat.full   = (count_q >= cap_q);
	assign stat.empty  = (count_q == '0);
	assign stat.pos_ok = (CNT_W'(pos_q) < count_q);
	assign stat.match  = (rd_data_q == value_q);
	assign stat.last   = ({1'b0, k_q} + (CNT_W + 1)'(1)) == {1'b0, count_q};

	// ring memory
	always_ff @(posedge clk) begin
		if (cmd.add_wr) begin
			mem[AW'(tail)] <= value_q;
		end
		if (rd_en) begin
			rd_data_q <= mem[AW'(rd_addr)];
		end
	end

	// command beat capture
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q  <= kind_t'(kind);
			value_q <= value[WORD_BITS-1:0];
			pos_q   <= position;
		end
	end

	// queue pointers and capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= clamp_cap(CAP_RESET);
			head_q  <= '0;
			count_q <= '0;
		end else if (capacity_we) begin
			cap_q   <= clamp_cap(capacity);
			head_q  <= '0;
			count_q <= '0;
		end else begin
			count_q <= count_d;
			if (cmd.pop_adv) begin
				head_q <= head_inc;
			end
		end
	end

	// search walk
	always_ff @(posedge clk) begin
		if (cmd.rd_head) begin
			ptr_q <= rd_addr_inc;
			k_q   <= '0;
		end else if (cmd.rd_next) begin
			ptr_q <= rd_addr_inc;
			k_q   <= k_q + CNT_W'(1);
		end
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.res_en;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_en) begin
			status_q <= cmd.res_status;
			data_q   <= cmd.res_data ? DATA_W'(rd_data_q) : '0;
			found_q  <= cmd.res_found ? k_q[POS_W-1:0] : '0;
			occ_q    <= count_d;
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign data_out       = data_q;
	assign found_position = found_q;
	assign occupancy      = occ_q;

endmodule

// ===== hdl/circular_queue_with_search.sv =====
`timescale 1ns / 1ps
// top level of the circular queue with search: controller plus datapath
// depends on cqs_pkg, cqs_ctrl and cqs_dp
//
// usage
//   command channel: a beat (kind, value, position) is taken at a rising edge
//   with start high and busy low. busy stays high while the command runs.
//   result channel: one result per command, shown for exactly one cycle with
//   done high (status, data_out, found_position, occupancy). the receiver
//   cannot stall, so results are never held back.
//   capacity: written with capacity_we while idle; the write also empties
//   the queue. zero acts as one, values above DEPTH act as DEPTH.
// timing
//   add, pop and a rejected get or search: done follows from the execute state;
//   a get in range first passes the S_GET_WAIT state for the memory read. search
//   reads one ring entry per cycle through the registered memory port, so a hit
//   ends at the matching entry and a miss ends after all occupied entries.
//   a new command may be issued in the cycle that done is high.
// reset
//   arst_n clears the queue to empty with capacity 16 (clamped to DEPTH);
//   no clearing pass runs, ring contents are undefined until written.
module circular_queue_with_search #(
	parameter int DEPTH = cqs_pkg::DEPTH_DEF,
	parameter int WORD_BITS = cqs_pkg::WORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// command channel
	input  logic                          start,
	output logic                          busy,
	input  logic [cqs_pkg::KIND_W-1:0]    kind,
	input  logic [cqs_pkg::DATA_W-1:0]    value,
	input  logic [cqs_pkg::POS_W-1:0]     position,
	// capacity register
	input  logic                          capacity_we,
	input  logic [cqs_pkg::CNT_W-1:0]     capacity,
	// result channel
	output logic                          done,
	output logic [cqs_pkg::STATUS_W-1:0]  status,
	output logic [cqs_pkg::DATA_W-1:0]    data_out,
	output logic [cqs_pkg::POS_W-1:0]     found_position,
	output logic [cqs_pkg::CNT_W-1:0]     occupancy
);
	import cqs_pkg::*;

	// highest occupancy the queue can ever report
	localparam int OCC_LIM = (DEPTH < (2 ** CNT_W - 1)) ? DEPTH : (2 ** CNT_W - 1);

	cqs_cmd_t  cmd;
	cqs_stat_t stat;

	// sequencer: one command at a time
	cqs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// ring memory, pointers and result beat registers
	cqs_dp #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.kind           (kind),
		.value          (value),
		.position       (position),
		.capacity_we    (capacity_we),
		.capacity       (capacity),
		.done           (done),
		.status         (status),
		.data_out       (data_out),
		.found_position (found_position),
		.occupancy      (occupancy)
	);

	// a result beat only ever leaves while the sequencer is back in idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	// an accepted command always makes the block busy next cycle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not start");

	// a write into the ring never happens on a full queue
	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.add_wr |-> !stat.full)
		else $error("add written into full queue");

	// reported occupancy stays within the ring
	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(occupancy) <= OCC_LIM))
		else $error("occupancy beyond ring size");

	// only a good get carries data
	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_OK)) |-> (data_out == '0))
		else $error("data on a failed command");

endmodule
